// ----- hw/rtl/i2cbs_pkg.sv -----
// Types, codes and step helpers shared by the I2C master bit sequencer.
package i2cbs_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DELAY_WIDTH = 16;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A, PH_ST_B,
    PH_SP_A, PH_SP_B,
    PH_WB_LOW, PH_WB_DATA, PH_WB_HIGH,
    PH_WA_LOW, PH_WA_HIGH, PH_WA_END,
    PH_RB_LOW, PH_RB_HIGH,
    PH_RA_LOW, PH_RA_HIGH, PH_RA_END
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       master_nack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       slave_nack;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
    logic       nack;
  } seq_state_t;

  // Move into a step and apply the line changes that open it.
  function automatic seq_state_t enter_step(seq_state_t s_in, phase_t ph);
    seq_state_t s;
    s = s_in;
    s.phase = ph;
    case (ph)
      PH_ST_A:    begin s.sda = 1'b1; s.scl = 1'b1; end
      PH_ST_B:    s.sda = 1'b0;
      PH_SP_A:    begin s.sda = 1'b0; s.scl = 1'b1; end
      PH_SP_B:    s.sda = 1'b1;
      PH_WB_LOW:  s.scl = 1'b0;
      PH_WB_DATA: begin
        s.sda = s.shift[7];
        s.shift = {s.shift[6:0], 1'b0};
      end
      PH_WB_HIGH: s.scl = 1'b1;
      PH_WA_LOW:  begin s.scl = 1'b0; s.sda = 1'b1; end
      PH_WA_HIGH: s.scl = 1'b1;
      PH_WA_END:  s.scl = 1'b0;
      PH_RB_LOW:  s.scl = 1'b0;
      PH_RB_HIGH: s.scl = 1'b1;
      PH_RA_LOW:  begin s.scl = 1'b0; s.sda = s.nack; end
      PH_RA_HIGH: s.scl = 1'b1;
      PH_RA_END:  s.scl = 1'b0;
      default:    s.phase = PH_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/i2cbs_in_if.sv -----
// Valid/ready channel carrying one tick item into the sequencer.
interface i2cbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       master_nack;
  logic       sda_in;

  modport source (output valid, output opcode, output data_byte, output master_nack,
                  output sda_in, input ready);
  modport sink (input valid, input opcode, input data_byte, input master_nack,
                input sda_in, output ready);
endinterface

// ----- hw/rtl/i2cbs_out_if.sv -----
// Valid/ready channel carrying one tick result out of the sequencer.
interface i2cbs_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       ready_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       slave_nack;

  modport source (output valid, output scl_out, output sda_out, output ready_res,
                  output done_res, output rx_byte, output slave_nack, input ready);
  modport sink (input valid, input scl_out, input sda_out, input ready_res,
                input done_res, input rx_byte, input slave_nack, output ready);
endinterface

// ----- hw/rtl/i2cbs_core.sv -----
// Bit sequencer state and per-tick step logic.
module i2cbs_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  i2cbs_pkg::item_t                  item,
  input  logic [i2cbs_pkg::DELAY_WIDTH-1:0] delay,
  output i2cbs_pkg::res_t                   res
);
  import i2cbs_pkg::*;

  seq_state_t             st_r, st_nxt;
  logic [COUNT_WIDTH-1:0] wait_r, wait_nxt;

  always_comb begin
    seq_state_t             s;
    logic [COUNT_WIDTH-1:0] ld;
    logic [COUNT_WIDTH-1:0] wc;
    logic                   rdy;
    logic                   done;
    logic                   scl_now;
    logic                   sda_now;

    s    = st_r;
    wc   = wait_r;
    done = 1'b0;
    // a zero delay still spends one tick per wait
    ld   = (delay == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(delay);
    rdy  = (s.phase == PH_IDLE);

    if (rdy) begin
      case (op_t'(item.opcode))
        OP_START: begin
          s  = enter_step(s, PH_ST_A);
          wc = ld;
        end
        OP_STOP: begin
          s  = enter_step(s, PH_SP_A);
          wc = ld;
        end
        OP_WRITE: begin
          s.shift     = item.data_byte;
          s.bit_count = '0;
          s           = enter_step(s, PH_WB_LOW);
          wc          = ld;
        end
        OP_READ: begin
          s.sda       = 1'b1;
          s.shift     = '0;
          s.bit_count = '0;
          s.nack      = item.master_nack;
          s           = enter_step(s, PH_RB_LOW);
          wc          = ld;
        end
        default: ;
      endcase
    end

    scl_now = s.scl;
    sda_now = s.sda;

    if (s.phase != PH_IDLE) begin
      if (wc != '0) wc = wc - COUNT_WIDTH'(1);
      if (wc == '0) begin
        wc = ld;
        case (s.phase)
          PH_ST_A:    s = enter_step(s, PH_ST_B);
          PH_SP_A:    s = enter_step(s, PH_SP_B);
          PH_WB_LOW:  s = enter_step(s, PH_WB_DATA);
          PH_WB_DATA: s = enter_step(s, PH_WB_HIGH);
          PH_WB_HIGH: begin
            s.bit_count = s.bit_count + 4'd1;
            s = enter_step(s, (s.bit_count < 4'd8) ? PH_WB_LOW : PH_WA_LOW);
          end
          PH_WA_LOW:  s = enter_step(s, PH_WA_HIGH);
          PH_WA_HIGH: begin
            s.ack = item.sda_in;
            s     = enter_step(s, PH_WA_END);
          end
          PH_RB_LOW:  s = enter_step(s, PH_RB_HIGH);
          PH_RB_HIGH: begin
            // sample at the end of SCL high, MSB first
            s.shift     = {s.shift[6:0], item.sda_in};
            s.bit_count = s.bit_count + 4'd1;
            if (s.bit_count < 4'd8) begin
              s = enter_step(s, PH_RB_LOW);
            end else begin
              s.rx = s.shift;
              s    = enter_step(s, PH_RA_LOW);
            end
          end
          PH_RA_LOW:  s = enter_step(s, PH_RA_HIGH);
          PH_RA_HIGH: s = enter_step(s, PH_RA_END);
          default: begin
            s.phase = PH_IDLE;
            wc      = '0;
            done    = 1'b1;
          end
        endcase
      end
    end

    st_nxt         = s;
    wait_nxt       = wc;
    res.scl_out    = scl_now;
    res.sda_out    = sda_now;
    res.ready_res  = rdy;
    res.done_res   = done;
    res.rx_byte    = s.rx;
    res.slave_nack = s.ack;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.bit_count <= '0;
      st_r.shift     <= '0;
      st_r.scl       <= 1'b1;
      st_r.sda       <= 1'b1;
      st_r.rx        <= '0;
      st_r.ack       <= 1'b0;
      st_r.nack      <= 1'b0;
      wait_r         <= '0;
    end else if (adv) begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
    end
  end

endmodule

// ----- hw/rtl/i2c_master_bit_sequencer.sv -----
// I2C master bit sequencer top level: tick channel, result channel, delay register.
//
//   channel | dir | handshake     | transaction
//   in_ch   | in  | valid/ready   | one bus tick: opcode, data_byte, master_nack, sda_in
//   out_ch  | out | valid/ready   | one tick result: scl/sda drive, ready, done, rx, nack
//   cfg     | in  | cfg_we        | delay_ticks write, 16 bits
//
// One tick per cycle while out_ch is not stalled: a tick passes an input register, then the step logic
// (one 16-bit counter decrement and compare) writes state and the result register.
// Result valid rises once the tick has passed from the input register into the result register.
// Reset (synchronous, rst_n low) idles the sequencer with both lines released
// and delay_ticks at 10. A stalled out_ch holds the result register and the
// input register, and in_ch.ready drops once both are full.
module i2c_master_bit_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cbs_in_if.sink                          in_ch,
  i2cbs_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [i2cbs_pkg::DELAY_WIDTH-1:0] cfg_wdata
);
  import i2cbs_pkg::*;

  logic [DELAY_WIDTH-1:0] delay_r;
  logic                   s1_valid_r, s1_valid_nxt;
  item_t                  s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_res_r;
  res_t                   step_res;
  logic                   out_free;
  logic                   adv;
  logic                   in_take;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  i2cbs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .delay (delay_r),
    .res   (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= DELAY_WIDTH'(10);
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) delay_r <= cfg_wdata;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode      <= in_ch.opcode;
      s1_item_r.data_byte   <= in_ch.data_byte;
      s1_item_r.master_nack <= in_ch.master_nack;
      s1_item_r.sda_in      <= in_ch.sda_in;
    end
    if (adv) out_res_r <= step_res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_out    = out_res_r.scl_out;
  assign out_ch.sda_out    = out_res_r.sda_out;
  assign out_ch.ready_res  = out_res_r.ready_res;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.rx_byte    = out_res_r.rx_byte;
  assign out_ch.slave_nack = out_res_r.slave_nack;

endmodule
